[rtl/core/u8d_pkg.sv]
// Shared types, constants and byte classification for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int CP_W            = 21;
  localparam int CNT_W           = 3;
  localparam int ERR_W           = 3;
  localparam int HOLD_DEPTH      = 3;
  localparam int HOLD_IDX_W      = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CNT_W-1:0] LEN_BAD   = CNT_W'(0);
  localparam logic [CNT_W-1:0] LEN_ASCII = CNT_W'(1);
  localparam logic [CNT_W-1:0] LEN_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] LEN_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] LEN_FOUR  = CNT_W'(4);

  typedef struct packed {
    logic [ERR_W-1:0] err_cnt;
    logic             has_valid;
    logic [CP_W-1:0]  cp;
    logic [CNT_W-1:0] vcnt;
    logic             fin;
  } step_t;

  function automatic logic [CNT_W-1:0] seq_len(input logic [7:0] b);
    logic [CNT_W-1:0] len;
    case (b) inside
      8'b0???????: len = LEN_ASCII;
      8'b110?????: len = LEN_TWO;
      8'b1110????: len = LEN_THREE;
      8'b11110???: len = LEN_FOUR;
      default:     len = LEN_BAD;
    endcase
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

[rtl/core/u8d_if.sv]
// Valid/ready channel interfaces for input bytes and decoded results.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source(output valid, output in_byte, output final_byte, input ready);
  modport sink(input valid, input in_byte, input final_byte, output ready);
endinterface

interface u8d_result_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::CP_W-1:0]     code_point;
  logic                         valid_res;
  logic [u8d_pkg::CNT_W-1:0]    byte_count;
  logic                         last_of_run;
  logic                         text_done;

  modport source(output valid, output code_point, output valid_res, output byte_count,
                 output last_of_run, output text_done, input ready);
  modport sink(input valid, input code_point, input valid_res, input byte_count,
               input last_of_run, input text_done, output ready);
endinterface

[rtl/core/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder: front end, step queue and result back end.
// The block takes one byte per cycle while its queue has room and returns one result
// transaction per cycle while the output is ready. A byte that completes a sequence or is
// a plain ASCII byte yields one result; a byte that breaks a pending sequence yields up to
// four results, which the back end sends one per cycle while the output is ready, so that
// byte holds the output until all are taken. The queue of QUEUE_DEPTH classified steps
// lets input flow while a burst drains; input ready drops only when the queue is full. A
// result goes via a queue entry and the output register; bytes that only extend a sequence give none.
module utf8_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  u8d_byte_if.sink      bytes,
  u8d_result_if.source  results
);
  import u8d_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  step_t push_step;
  step_t head_step;

  u8d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .step  (push_step)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_step  (push_step),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_step  (head_step)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_step  (head_step),
    .pop        (pop),
    .results    (results)
  );

endmodule

[rtl/core/u8d_front.sv]
// Front end: accepts bytes, tracks the pending sequence and classifies each step.
module u8d_front (
  input  logic           clk,
  input  logic           rst,
  u8d_byte_if.sink       bytes,
  input  logic           full,
  output logic           push,
  output u8d_pkg::step_t step
);
  import u8d_pkg::*;

  logic [7:0]            held_bytes [HOLD_DEPTH];
  logic [HOLD_IDX_W-1:0] held_count;
  logic [HOLD_IDX_W-1:0] held_count_next;
  logic                  hold_we;
  logic [HOLD_IDX_W-1:0] hold_idx;
  logic                  accept;
  logic [7:0]            b;
  logic                  fin;
  logic [CNT_W-1:0]      lb;
  logic [CNT_W-1:0]      hl;
  logic [ERR_W-1:0]      pre;
  logic [CP_W-1:0]       cp_multi;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign b           = bytes.in_byte;
  assign fin         = bytes.final_byte;
  assign lb          = seq_len(b);
  assign hl          = seq_len(held_bytes[0]);
  assign pre         = {1'b0, held_count};

  always_comb begin
    case (hl)
      LEN_TWO:   cp_multi = CP_W'({held_bytes[0][4:0], b[5:0]});
      LEN_THREE: cp_multi = CP_W'({held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]});
      LEN_FOUR:  cp_multi = CP_W'({held_bytes[0][2:0], held_bytes[1][5:0],
                                   held_bytes[2][5:0], b[5:0]});
      default:   cp_multi = '0;
    endcase
  end

  always_comb begin
    step.err_cnt    = '0;
    step.has_valid  = 1'b0;
    step.cp         = '0;
    step.vcnt       = LEN_ASCII;
    step.fin        = fin;
    held_count_next = '0;
    hold_we         = 1'b0;
    hold_idx        = '0;
    if (held_count == '0 || !is_cont(b)) begin
      step.err_cnt = pre;
      case (lb)
        LEN_ASCII: begin
          step.has_valid = 1'b1;
          step.cp        = CP_W'(b[6:0]);
        end
        LEN_BAD: begin
          step.err_cnt = pre + ERR_W'(1);
        end
        default: begin
          if (fin) begin
            step.err_cnt = pre + ERR_W'(1);
          end else begin
            hold_we         = 1'b1;
            held_count_next = HOLD_IDX_W'(1);
          end
        end
      endcase
    end else if (pre + ERR_W'(1) == hl) begin
      step.has_valid = 1'b1;
      step.cp        = cp_multi;
      step.vcnt      = hl;
    end else if (fin) begin
      step.err_cnt = pre + ERR_W'(1);
    end else begin
      hold_we         = 1'b1;
      hold_idx        = held_count;
      held_count_next = held_count + HOLD_IDX_W'(1);
    end
  end

  assign push = accept && (step.err_cnt != '0 || step.has_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_bytes[hold_idx] <= b;
    end
  end

endmodule

[rtl/core/u8d_queue.sv]
// Short queue of classified steps between the front and back ends.
module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u8d_pkg::step_t push_step,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output u8d_pkg::step_t head_step
);
  import u8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  step_t              entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full       = fill == FILL_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head_step  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_step;
    end
  end

endmodule

[rtl/core/u8d_back.sv]
// Back end: expands each queued step into result transactions on a registered output.
module u8d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  u8d_pkg::step_t head_step,
  output logic           pop,
  u8d_result_if.source   results
);
  import u8d_pkg::*;

  logic [ERR_W-1:0] sent;
  logic             load;
  logic             emit;
  logic             is_err;
  logic             last;

  assign load   = !results.valid || results.ready;
  assign emit   = load && head_valid;
  assign is_err = sent < head_step.err_cnt;
  assign last   = is_err ? (sent + ERR_W'(1) == head_step.err_cnt && !head_step.has_valid)
                         : 1'b1;
  assign pop    = emit && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      sent          <= '0;
    end else begin
      if (load) begin
        results.valid <= head_valid;
      end
      if (emit) begin
        sent <= last ? '0 : sent + ERR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.code_point  <= is_err ? '0 : head_step.cp;
      results.valid_res   <= !is_err;
      results.byte_count  <= is_err ? LEN_ASCII : head_step.vcnt;
      results.last_of_run <= last;
      results.text_done   <= last && head_step.fin;
    end
  end

endmodule

[sim/tb_utf8_stream_decoder_unit.sv]
// Self-checking testbench for the UTF-8 stream decoder with random stalls on both channels.
module tb_utf8_stream_decoder_unit;
  import u8d_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 100;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned RANDOM_TARGET    = 120;
  localparam int unsigned PRESSURE_BYTES   = 30;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             valid_res;
    logic [CNT_W-1:0] byte_count;
    logic             last_of_run;
    logic             text_done;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  u8d_byte_if   byte_ch ();
  u8d_result_if res_ch ();

  utf8_stream_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (res_ch)
  );

  result_t     pending_cps[$];
  logic [7:0]  held_text[HOLD_DEPTH];
  int unsigned held_len     = 0;
  int unsigned errors       = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned bad_seen     = 0;
  int unsigned widest_burst = 0;
  logic        src_jitter   = 1'b1;
  logic        sink_jitter  = 1'b1;
  logic        long_hold    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned lead_len(input logic [7:0] b);
    if (b[7] == 1'b0) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  win[4];
    result_t     run[4];
    result_t     r;
    int unsigned n, pos, need, avail, cnt, i;
    logic        ok;
    for (i = 0; i < held_len; i++) win[i] = held_text[i];
    win[held_len] = b;
    n = held_len + 1;
    pos = 0;
    cnt = 0;
    while (pos < n && cnt < 4) begin
      need = lead_len(win[pos]);
      avail = n - pos;
      ok = (need != 0);
      for (i = 1; i < need && i < avail; i++) begin
        if (win[pos+i][7:6] != 2'b10) ok = 1'b0;
      end
      if (ok && avail < need) begin
        if (!fin) break;
        ok = 1'b0;
      end
      r = '0;
      r.valid_res  = ok;
      r.byte_count = CNT_W'(1);
      if (ok) begin
        r.byte_count = CNT_W'(need);
        case (need)
          1: r.code_point = {14'b0, win[pos][6:0]};
          2: r.code_point = {10'b0, win[pos][4:0], win[pos+1][5:0]};
          3: r.code_point = {5'b0, win[pos][3:0], win[pos+1][5:0], win[pos+2][5:0]};
          default: r.code_point = {win[pos][2:0], win[pos+1][5:0], win[pos+2][5:0],
                                   win[pos+3][5:0]};
        endcase
        pos += need;
      end else begin
        pos += 1;
      end
      run[cnt] = r;
      cnt++;
    end
    if (cnt > 0) begin
      run[cnt-1].last_of_run = 1'b1;
      run[cnt-1].text_done   = fin;
    end
    for (i = 0; i < cnt; i++) pending_cps.push_back(run[i]);
    if (cnt > widest_burst) widest_burst = cnt;
    if (fin || pos >= n) begin
      held_len = 0;
    end else begin
      held_len = (n - pos > 3) ? 3 : n - pos;
      for (i = 0; i < held_len; i++) held_text[i] = win[pos+i];
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (pending_cps.size() == 0) begin
      $display("%0t: unexpected result, expected none, got code_point %0h valid_res %0b",
               $time, res_ch.code_point, res_ch.valid_res);
      errors++;
      return;
    end
    want = pending_cps.pop_front();
    results_seen++;
    if (!want.valid_res) bad_seen++;
    check_field("code_point", want.code_point, res_ch.code_point);
    check_field("valid_res", want.valid_res, res_ch.valid_res);
    check_field("byte_count", want.byte_count, res_ch.byte_count);
    check_field("last_of_run", want.last_of_run, res_ch.last_of_run);
    check_field("text_done", want.text_done, res_ch.text_done);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result();
  end

  initial begin
    int unsigned pause;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      pause = sink_jitter ? $urandom_range(0, 3) : 0;
      if (pause > 0) begin
        res_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = src_jitter ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.in_byte    <= b;
    byte_ch.final_byte <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cps.size() != 0) @(posedge clk);
  endtask

  task automatic send_text_char();
    int unsigned kind, len, i, stop;
    logic [7:0]  lead, cont;
    logic        fin;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: lead = {1'b0, 7'($urandom)};
      2: lead = {3'b110, 5'($urandom)};
      3: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    stop = (kind < 18 && len > 1) ? $urandom_range(1, len - 1) : len;
    fin = (len == 1 || (kind >= 13 && kind < 18)) ? (stop == 1 && $urandom_range(0, 7) == 0)
                                                  : 1'b0;
    if (kind >= 13 && kind < 18 && stop == 1) fin = 1'b1;
    send_byte(lead, fin);
    for (i = 1; i < stop; i++) begin
      cont = {2'b10, 6'($urandom)};
      if (kind >= 18 && kind < 24 && i == len - 1) cont = 8'($urandom_range(0, 255));
      fin = (i == stop - 1) && ((kind >= 13 && kind < 18) || $urandom_range(0, 15) == 0);
      send_byte(cont, fin);
    end
  endtask

  task automatic test_valid_forms();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    drain_results();
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h41, 1'b0);
    drain_results();
  endtask

  task automatic test_end_of_text();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);
    drain_results();
  endtask

  task automatic test_random_text();
    int unsigned start;
    while (bytes_sent < RANDOM_TARGET) begin
      start = bytes_sent;
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      while (bytes_sent < start + 25) send_text_char();
    end
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    drain_results();
  endtask

  task automatic test_output_backpressure();
    int unsigned start;
    start = bytes_sent;
    src_jitter = 1'b0;
    long_hold  = 1'b1;
    while (bytes_sent < start + PRESSURE_BYTES) begin
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h41, 1'b0);
      end else begin
        send_text_char();
      end
    end
    src_jitter = 1'b1;
    drain_results();
  endtask

  initial begin
    rst                <= 1'b1;
    byte_ch.valid      <= 1'b0;
    byte_ch.in_byte    <= 8'h00;
    byte_ch.final_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_valid_forms();
    test_bad_bytes();
    test_end_of_text();
    test_random_text();
    test_output_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d bytes and %0d results (%0d invalid), up to %0d from one byte",
             bytes_sent, results_seen, bad_seen, widest_burst);
    $display("with random stalls on both channels and one long output hold-off");
    if (errors == 0) begin
      $display("tb_utf8_stream_decoder_unit: clean");
    end else begin
      $display("tb_utf8_stream_decoder_unit: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_cps.size());
    $display("tb_utf8_stream_decoder_unit: errors");
    $finish;
  end

endmodule

[files.f]
rtl/core/u8d_pkg.sv
rtl/core/u8d_if.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder_unit.sv
sim/tb_utf8_stream_decoder_unit.sv
